>>> hdl/rpc_pkg.sv
// ----------------------------------------------------------------------------
// rpc_pkg
// Shared types, mode codes and the divide-by-255 helper for the RGBA pixel
// combiner.
// ----------------------------------------------------------------------------
package rpc_pkg;

   // number of quotient bits, one per divider cell
   localparam int unsigned DIV_BITS = 8;
   localparam logic [7:0]  CH_MAX   = 8'hff;
   localparam logic [7:0]  CH_ZERO  = 8'h00;

   typedef enum logic [1:0] {
      MODE_BLEND   = 2'd0,
      MODE_DARKEN  = 2'd1,
      MODE_LIGHTEN = 2'd2,
      MODE_PASS    = 2'd3
   } mode_type;

   // red in the lowest byte, so the struct lines up with the tdata packing
   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pix_type;

   // pixel that leaves the block, or the alpha/divisor when use_div is set
   typedef struct packed {
      logic    use_div;
      pix_type pix;
   } side_type;

   // one channel of the restoring divider: remainder and shifting low bits
   typedef struct packed {
      logic [7:0] rem;
      logic [7:0] low;
   } div_type;

   // word moved from cell to cell
   typedef struct packed {
      side_type          side;
      logic [2:0]        sat;
      div_type [2:0]     chan;
   } cell_type;

   // floor(v / 255) for v below 255*65025: reciprocal estimate by 257/65536,
   // which never overshoots, then one compare and step up
   function automatic logic [15:0] div255(input logic [23:0] v);
      logic [32:0] p;
      logic [15:0] q;
      logic [23:0] r;
      p = ({9'd0, v} << 8) + {9'd0, v};
      q = p[31:16];
      r = v - (({8'd0, q} << 8) - {8'd0, q});
      return (r >= 24'd255) ? q + 16'd1 : q;
   endfunction

endpackage

>>> hdl/rgba_pixel_combine.sv
// ----------------------------------------------------------------------------
// rgba_pixel_combine
// Combines an RGBA destination pixel with a source pixel (alpha-over) or a
// factor (darken, lighten) or passes it on; one word per cycle while not stalled.
// ----------------------------------------------------------------------------
// Path: a word accepted on req passes 6 front stages, 8 divider cells and
//   1 output register before it shows on rsp_tvalid.
// Throughput: one word per cycle while the output is not stalled; the 8-cell
//   un-premultiply divider chain is fully pipelined: it sets depth, not rate.
// Reset: synchronous, active high; empties every stage, nothing to clear.
// ----------------------------------------------------------------------------
module rgba_pixel_combine
   import rpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: dst_red, dst_green, dst_blue, dst_alpha, src_red, src_green,
   //        src_blue, src_alpha, factor (lowest bit up)
   input  logic [71:0] req_tdata,
   // tuser: mode
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: out_red, out_green, out_blue, out_alpha (lowest bit up)
   output logic [31:0] rsp_tdata
);

   logic     [DIV_BITS:0] cv;
   logic     [DIV_BITS:0] cr;
   cell_type [DIV_BITS:0] cw;

   logic     rsp_tvalid_ff;
   pix_type  rsp_pix_ff;
   pix_type  rsp_pix_in;
   logic     out_en;

   rpc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .mode      (req_tuser),
      .dst       (pix_type'(req_tdata[31:0])),
      .src       (pix_type'(req_tdata[63:32])),
      .factor    (req_tdata[71:64]),
      .out_valid (cv[0]),
      .out_ready (cr[0]),
      .out_word  (cw[0])
   );

   // divider chain, one quotient bit per cell
   for (genvar k = 0; k < DIV_BITS; k++) begin : g_cell
      rpc_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cv[k]),
         .in_ready  (cr[k]),
         .in_word   (cw[k]),
         .out_valid (cv[k+1]),
         .out_ready (cr[k+1]),
         .out_word  (cw[k+1])
      );
   end

   assign out_en        = !rsp_tvalid_ff || rsp_tready;
   assign cr[DIV_BITS]  = out_en;

   // pick the quotient or the bypass pixel
   always_comb begin
      rsp_pix_in = cw[DIV_BITS].side.pix;
      if (cw[DIV_BITS].side.use_div) begin
         rsp_pix_in.red   = cw[DIV_BITS].sat[0] ? CH_MAX : cw[DIV_BITS].chan[0].low;
         rsp_pix_in.green = cw[DIV_BITS].sat[1] ? CH_MAX : cw[DIV_BITS].chan[1].low;
         rsp_pix_in.blue  = cw[DIV_BITS].sat[2] ? CH_MAX : cw[DIV_BITS].chan[2].low;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (out_en) begin
         rsp_tvalid_ff <= cv[DIV_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         rsp_pix_ff <= rsp_pix_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_pix_ff;

endmodule

>>> hdl/rpc_div_cell.sv
// ----------------------------------------------------------------------------
// rpc_div_cell
// One step of the restoring divider: produces one quotient bit per colour
// channel and hands the word on to the next cell.
// ----------------------------------------------------------------------------
module rpc_div_cell
   import rpc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  cell_type in_word,
   output logic     out_valid,
   input  logic     out_ready,
   output cell_type out_word
);

   logic     valid_ff;
   cell_type word_ff;
   cell_type word_in;

   assign in_ready = !valid_ff || out_ready;

   // shift in the next dividend bit, subtract the divisor where it fits
   always_comb begin
      logic [8:0] part;
      logic       fits;
      word_in = in_word;
      for (int i = 0; i < 3; i++) begin
         part = {in_word.chan[i].rem, in_word.chan[i].low[7]};
         fits = part >= {1'b0, in_word.side.pix.alpha};
         word_in.chan[i].rem = fits ? 8'(part - {1'b0, in_word.side.pix.alpha})
                                    : part[7:0];
         word_in.chan[i].low = {in_word.chan[i].low[6:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

>>> hdl/rpc_front.sv
// ----------------------------------------------------------------------------
// rpc_front
// Six-stage front end: products, divisions by 255, mode selection and the
// set-up of the divider word for the un-premultiply.
// ----------------------------------------------------------------------------
module rpc_front
   import rpc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [1:0] mode,
   input  pix_type    dst,
   input  pix_type    src,
   input  logic [7:0] factor,
   output logic       out_valid,
   input  logic       out_ready,
   output cell_type   out_word
);

   typedef struct packed {
      mode_type          mode;
      pix_type           dst;
      pix_type           src;
      logic [2:0][15:0]  dp;
      logic [2:0][15:0]  ss;
      logic [2:0][15:0]  df;
      logic [15:0]       nap;
   } st1_type;

   typedef struct packed {
      side_type          side;
      logic [2:0][23:0]  x;
      logic [2:0][15:0]  ss;
   } st2_type;

   typedef struct packed {
      side_type          side;
      logic [2:0][15:0]  xq;
      logic [2:0][15:0]  ss;
   } st3_type;

   typedef struct packed {
      side_type          side;
      logic [2:0][16:0]  sum;
   } st4_type;

   typedef struct packed {
      side_type          side;
      logic [2:0][7:0]   t;
   } st5_type;

   logic [5:0] valid_ff;
   logic [5:0] en;
   st1_type    s1_ff, s1_in;
   st2_type    s2_ff, s2_in;
   st3_type    s3_ff, s3_in;
   st4_type    s4_ff, s4_in;
   st5_type    s5_ff, s5_in;
   cell_type   s6_ff, s6_in;

   // stage ready chain: a stage moves when it is empty or its successor moves
   always_comb begin
      en[5] = !valid_ff[5] || out_ready;
      for (int k = 4; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end
   assign in_ready = en[0];

   // stage 1: the 8x8 products
   always_comb begin
      logic [2:0][7:0] dc;
      logic [2:0][7:0] sc;
      dc = {dst.blue, dst.green, dst.red};
      sc = {src.blue, src.green, src.red};
      s1_in.mode = mode_type'(mode);
      s1_in.dst  = dst;
      s1_in.src  = src;
      for (int i = 0; i < 3; i++) begin
         s1_in.dp[i] = {8'd0, dc[i]} * {8'd0, dst.alpha};
         s1_in.ss[i] = {8'd0, sc[i]} * {8'd0, src.alpha};
         s1_in.df[i] = {8'd0, dc[i]} * {8'd0, factor};
      end
      s1_in.nap = {8'd0, src.alpha} * {8'd0, CH_MAX - dst.alpha};
   end

   // stage 2: destination term of alpha-over, new alpha, darken and lighten
   always_comb begin
      logic [2:0][7:0] dc;
      logic [2:0][7:0] dd;
      logic [2:0][7:0] dk;
      logic [2:0][7:0] lt;
      logic [15:0]     q;
      logic [8:0]      up;
      logic [7:0]      na;
      logic [7:0]      sa;
      logic [7:0]      da;
      dc = {s1_ff.dst.blue, s1_ff.dst.green, s1_ff.dst.red};
      sa = s1_ff.src.alpha;
      da = s1_ff.dst.alpha;
      for (int i = 0; i < 3; i++) begin
         q     = div255({8'd0, s1_ff.df[i]});
         dd[i] = q[7:0];
         dk[i] = dc[i] - dd[i];
         up    = {1'b0, dc[i]} + {1'b0, dd[i]};
         lt[i] = up[8] ? CH_MAX : up[7:0];
         s2_in.x[i] = {8'd0, s1_ff.dp[i]} * {16'd0, CH_MAX - sa};
      end
      q  = div255({8'd0, s1_ff.nap});
      na = da + q[7:0];
      s2_in.ss           = s1_ff.ss;
      s2_in.side.use_div = 1'b0;
      s2_in.side.pix     = s1_ff.dst;
      unique case (s1_ff.mode)
         MODE_BLEND: begin
            priority if (sa == CH_ZERO) begin
               s2_in.side.pix = s1_ff.dst;
            end else if (sa == CH_MAX || da == CH_ZERO) begin
               s2_in.side.pix = s1_ff.src;
            end else begin
               s2_in.side.use_div   = 1'b1;
               s2_in.side.pix.alpha = na;
            end
         end
         MODE_DARKEN: begin
            s2_in.side.pix.red   = dk[0];
            s2_in.side.pix.green = dk[1];
            s2_in.side.pix.blue  = dk[2];
         end
         MODE_LIGHTEN: begin
            s2_in.side.pix.red   = lt[0];
            s2_in.side.pix.green = lt[1];
            s2_in.side.pix.blue  = lt[2];
         end
         MODE_PASS: begin
            s2_in.side.pix = s1_ff.dst;
         end
         default: begin
            s2_in.side.pix = s1_ff.dst;
         end
      endcase
   end

   // stage 3: scale the destination term down by 255
   always_comb begin
      s3_in.side = s2_ff.side;
      s3_in.ss   = s2_ff.ss;
      for (int i = 0; i < 3; i++) begin
         s3_in.xq[i] = div255(s2_ff.x[i]);
      end
   end

   // stage 4: add the source term
   always_comb begin
      s4_in.side = s3_ff.side;
      for (int i = 0; i < 3; i++) begin
         s4_in.sum[i] = {1'b0, s3_ff.ss[i]} + {1'b0, s3_ff.xq[i]};
      end
   end

   // stage 5: premultiplied channel t, kept to 8 bits
   always_comb begin
      logic [15:0] q;
      s5_in.side = s4_ff.side;
      for (int i = 0; i < 3; i++) begin
         q           = div255({7'd0, s4_ff.sum[i]});
         s5_in.t[i]  = q[7:0];
      end
   end

   // stage 6: dividend t*255; a high byte not below the divisor saturates
   always_comb begin
      logic [15:0] dvd;
      s6_in.side = s5_ff.side;
      for (int i = 0; i < 3; i++) begin
         dvd               = ({8'd0, s5_ff.t[i]} << 8) - {8'd0, s5_ff.t[i]};
         s6_in.sat[i]      = dvd[15:8] >= s5_ff.side.pix.alpha;
         s6_in.chan[i].rem = dvd[15:8];
         s6_in.chan[i].low = dvd[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[0]) valid_ff[0] <= in_valid;
         for (int k = 1; k < 6; k++) begin
            if (en[k]) valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) s1_ff <= s1_in;
      if (en[1]) s2_ff <= s2_in;
      if (en[2]) s3_ff <= s3_in;
      if (en[3]) s4_ff <= s4_in;
      if (en[4]) s5_ff <= s5_in;
      if (en[5]) s6_ff <= s6_in;
   end

   assign out_valid = valid_ff[5];
   assign out_word  = s6_ff;

endmodule

>>> hdl/rpc_checker.sv
// ----------------------------------------------------------------------------
// rpc_checker
// Port-level checks for the RGBA pixel combiner, bound to the top level.
// ----------------------------------------------------------------------------
module rpc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [71:0] req_tdata,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // reset empties the pipe
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word present straight after reset");

   // a waiting request word holds until it is taken
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=>
         req_tvalid && $stable(req_tdata) && $stable(req_tuser))
      else $error("request word changed while waiting");

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // back-pressure on the input only comes from a held result word
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without a stalled result");

   // a free output keeps the whole chain moving
   a_flow: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("input stalled while output is taken");

endmodule

bind rgba_pixel_combine rpc_checker u_rpc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> tb/sv/tb_rgba_pixel_combine.sv
// ----------------------------------------------------------------------------
// tb_rgba_pixel_combine
// Self-checking bench for the RGBA pixel combiner. A directed table covers
// the blend special cases, the darken and lighten extremes and the reserved
// mode. Random words follow under several sender and receiver idling patterns.
// Every result word is checked field by field against the typed pixel of its
// table row or else an in-bench compositing model.
// ----------------------------------------------------------------------------
module tb_rgba_pixel_combine
   import rpc_pkg::*;
();

   localparam int unsigned CH_FULL     = 255;
   localparam int unsigned DRAIN_WAIT  = 40;
   localparam int unsigned PHASE_WORDS = 400;
   localparam int unsigned NUM_ROWS    = 21;
   localparam int unsigned MAX_REPORTS = 10;

   // one row of the directed table; typed rows carry their expected pixel
   typedef struct {
      mode_type   mode;
      pix_type    dst;
      pix_type    src;
      logic [7:0] factor;
      bit         typed;
      pix_type    want;
   } stim_row_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;

   int unsigned send_idle_pct  = 0;
   int unsigned rsp_stall_pct  = 0;
   int unsigned mismatch_count = 0;

   pix_type expected_pixels [$];

   string chan_name [4] = '{"red", "green", "blue", "alpha"};

   //          mode          dst           src           fct    typed want
   stim_row_type directed_rows [NUM_ROWS] = '{
      // invisible source keeps the destination
      '{MODE_BLEND,   32'h80302010, 32'h00ffffff, 8'h00, 1'b1, 32'h80302010},
      '{MODE_BLEND,   32'hffffffff, 32'h00000000, 8'h00, 1'b1, 32'hffffffff},
      // opaque source or invisible destination copies the source
      '{MODE_BLEND,   32'hc0445566, 32'hff010203, 8'h00, 1'b1, 32'hff010203},
      '{MODE_BLEND,   32'h00445566, 32'h7faabbcc, 8'h00, 1'b1, 32'h7faabbcc},
      '{MODE_BLEND,   32'h00000000, 32'hffffffff, 8'hff, 1'b1, 32'hffffffff},
      // general alpha-over, tiny alphas probe the un-premultiply ceiling
      '{MODE_BLEND,   32'h804080c0, 32'h80c08040, 8'h00, 1'b0, 32'h0},
      '{MODE_BLEND,   32'h01ffffff, 32'h01ffffff, 8'h00, 1'b0, 32'h0},
      '{MODE_BLEND,   32'hfe000000, 32'hfeffffff, 8'h00, 1'b0, 32'h0},
      '{MODE_BLEND,   32'hffffffff, 32'h01000000, 8'h00, 1'b0, 32'h0},
      '{MODE_BLEND,   32'h01ff00ff, 32'hfe00ff00, 8'hff, 1'b0, 32'h0},
      // darken
      '{MODE_DARKEN,  32'h5aff8001, 32'h00000000, 8'h00, 1'b1, 32'h5aff8001},
      '{MODE_DARKEN,  32'h5aff8001, 32'h00000000, 8'hff, 1'b1, 32'h5a000000},
      '{MODE_DARKEN,  32'hffffffff, 32'h00000000, 8'h80, 1'b0, 32'h0},
      '{MODE_DARKEN,  32'h00000000, 32'hffffffff, 8'hff, 1'b1, 32'h00000000},
      '{MODE_DARKEN,  32'h8090a0b0, 32'hffffffff, 8'h40, 1'b0, 32'h0},
      // lighten, saturating at full scale
      '{MODE_LIGHTEN, 32'h5a0064ff, 32'h00000000, 8'hff, 1'b1, 32'h5a00c8ff},
      '{MODE_LIGHTEN, 32'h5a0064ff, 32'h00000000, 8'h00, 1'b1, 32'h5a0064ff},
      '{MODE_LIGHTEN, 32'hff7f8081, 32'h00000000, 8'hff, 1'b1, 32'hfffeffff},
      '{MODE_LIGHTEN, 32'h33102030, 32'hffffffff, 8'h55, 1'b0, 32'h0},
      // reserved mode passes the destination
      '{MODE_PASS,    32'h12345678, 32'hffffffff, 8'hff, 1'b1, 32'h12345678},
      '{MODE_PASS,    32'h00000000, 32'h00000000, 8'h00, 1'b1, 32'h00000000}
   };

   rgba_pixel_combine DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // clock, period 2
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // compositing model: one result pixel per input word
   function automatic pix_type composite_pixel(input mode_type mode, input pix_type dst,
                                               input pix_type src, input logic [7:0] factor);
      logic [3:0][7:0] d;
      logic [3:0][7:0] s;
      logic [3:0][7:0] r;
      int unsigned     sa;
      int unsigned     da;
      int unsigned     na;
      int unsigned     dp;
      int unsigned     t;
      int unsigned     q;
      int unsigned     f;
      int              ch;
      d  = dst;
      s  = src;
      r  = d;
      sa = s[3];
      da = d[3];
      f  = factor;
      case (mode)
         MODE_BLEND: begin
            if (sa == 0) begin
               r = d;
            end else if (sa == CH_FULL || da == 0) begin
               r = s;
            end else begin
               na = da + (sa * (CH_FULL - da)) / CH_FULL;
               for (ch = 0; ch < 3; ch++) begin
                  dp = d[ch] * da;
                  t  = ((s[ch] * sa + (dp * (CH_FULL - sa)) / CH_FULL) / CH_FULL) & 32'hff;
                  q  = (t * CH_FULL) / na;
                  r[ch] = (q > CH_FULL) ? CH_MAX : q[7:0];
               end
               r[3] = na[7:0];
            end
         end
         MODE_DARKEN: begin
            for (ch = 0; ch < 3; ch++) begin
               q = d[ch];
               q = q - (q * f) / CH_FULL;
               r[ch] = q[7:0];
            end
         end
         MODE_LIGHTEN: begin
            for (ch = 0; ch < 3; ch++) begin
               q = d[ch];
               q = q + (q * f) / CH_FULL;
               r[ch] = (q > CH_FULL) ? CH_MAX : q[7:0];
            end
         end
         default: r = d;
      endcase
      return r;
   endfunction

   // alpha biased towards the blend corner cases
   function automatic logic [7:0] pick_alpha();
      case ($urandom_range(0, 7))
         0:       return CH_ZERO;
         1:       return CH_MAX;
         2:       return 8'($urandom_range(1, 3));
         3:       return 8'($urandom_range(252, 254));
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] pick_channel();
      case ($urandom_range(0, 7))
         0:       return CH_ZERO;
         1:       return CH_MAX;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic mode_type pick_mode();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll < 5)
         return MODE_BLEND;
      else if (roll < 7)
         return MODE_DARKEN;
      else if (roll < 9)
         return MODE_LIGHTEN;
      return MODE_PASS;
   endfunction

   // drive one word, wait for its handshake, then queue its expected pixel
   task automatic send_word(input mode_type mode, input pix_type dst, input pix_type src,
                            input logic [7:0] factor, input pix_type want);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {factor, src, dst};
      do
         @(posedge clock);
      while (!req_tready);
      expected_pixels.push_back(want);
   endtask

   task automatic random_burst(input int unsigned words, input int unsigned idle_pct,
                               input int unsigned stall_pct);
      mode_type   mode;
      pix_type    dst;
      pix_type    src;
      logic [7:0] factor;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (words) begin
         mode   = pick_mode();
         dst    = {pick_alpha(), pick_channel(), pick_channel(), pick_channel()};
         src    = {pick_alpha(), pick_channel(), pick_channel(), pick_channel()};
         factor = pick_channel();
         send_word(mode, dst, src, factor, composite_pixel(mode, dst, src, factor));
      end
   endtask

   task automatic note_mismatch(input string what, input logic [7:0] want,
                                input logic [7:0] got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("mismatch on %s: expected %02h, got %02h", what, want, got);
   endtask

   // result checker and receiver stalls
   always @(posedge clock) begin
      logic [3:0][7:0] got;
      logic [3:0][7:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_pixels.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected result word %08h", rsp_tdata);
         end else begin
            want = expected_pixels.pop_front();
            for (int ch = 0; ch < 4; ch++)
               if (got[ch] !== want[ch])
                  note_mismatch(chan_name[ch], want[ch], got[ch]);
         end
      end
      rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // stimulus and end of run
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed table, no idling
      foreach (directed_rows[i])
         send_word(directed_rows[i].mode, directed_rows[i].dst, directed_rows[i].src,
                   directed_rows[i].factor,
                   directed_rows[i].typed ? directed_rows[i].want :
                      composite_pixel(directed_rows[i].mode, directed_rows[i].dst,
                                      directed_rows[i].src, directed_rows[i].factor));

      random_burst(PHASE_WORDS, 0, 0);
      random_burst(PHASE_WORDS, 87, 0);
      random_burst(PHASE_WORDS, 0, 87);
      random_burst(PHASE_WORDS, 8, 8);

      req_tvalid <= 1'b0;
      while (expected_pixels.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("rgba_pixel_combine regression: pass");
      end else begin
         $display("rgba_pixel_combine regression: fail");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("rgba_pixel_combine regression: fail");
      $finish;
   end

endmodule
